>>> hw/rtl/kdlr_pkg.sv
// Shared types, constants and register codes for the keypad debounce core.
// No dependencies; every other file in hw/rtl imports this package.
package kdlr_pkg;

  localparam int NUM_KEYS       = 3;
  localparam int KEY_LINES      = 3;
  localparam int QUEUE_DEPTH    = 16;
  localparam int NUM_SLOTS      = 2 * NUM_KEYS;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W         = $clog2(2 * QUEUE_DEPTH + NUM_SLOTS + 1);
  localparam int SLOT_W         = $clog2(NUM_SLOTS + 1);
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  localparam int CNT_W      = 10;
  localparam int HOLD_W     = 17;
  localparam int KIND_W     = 3;
  localparam int KEY_W      = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  FILTER_RST = 8'd5;
  localparam logic [7:0]  STEP_RST   = 8'd1;
  localparam logic [15:0] LONG_RST   = 16'd1000;
  localparam logic [15:0] REPEAT_RST = 16'd100;
  localparam logic [3:0]  MASK_RST   = 4'hF;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 3'd0,
    KIND_DOWN   = 3'd1,
    KIND_UP     = 3'd2,
    KIND_LONG   = 3'd3,
    KIND_REPEAT = 3'd4
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FILTER = 3'd0,
    REG_STEP   = 3'd1,
    REG_LONG   = 3'd2,
    REG_REPEAT = 3'd3,
    REG_MASK   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  filter_ticks;
    logic [7:0]  tick_step;
    logic [15:0] long_press_time;
    logic [15:0] repeat_interval;
    logic [3:0]  report_mask;
  } cfg_t;

  // One classified request: a pop, or the events of one scan tick.
  // Slot 2k carries the down/up event of key k, slot 2k+1 its long/repeat event.
  typedef struct packed {
    logic                              is_pop;
    logic [NUM_SLOTS-1:0][KIND_W-1:0]  kinds;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } qentry_t;

endpackage

>>> hw/rtl/kdlr_front.sv
// Front end: per-key counting debounce, hold and repeat timing, event classification.
// Depends on kdlr_pkg.
module kdlr_front import kdlr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_pop,
  input  logic [KEY_LINES-1:0] in_keys,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  logic [CNT_W-1:0]  debounce_count [NUM_KEYS];
  logic              key_is_down    [NUM_KEYS];
  logic [HOLD_W-1:0] hold_count     [NUM_KEYS];
  logic [HOLD_W-1:0] rep_count      [NUM_KEYS];

  logic [CNT_W-1:0]  debounce_count_next [NUM_KEYS];
  logic              key_is_down_next    [NUM_KEYS];
  logic [HOLD_W-1:0] hold_count_next     [NUM_KEYS];
  logic [HOLD_W-1:0] rep_count_next      [NUM_KEYS];
  logic [NUM_SLOTS-1:0][KIND_W-1:0] kinds;

  logic accept_tick;

  // Drop the event when its report bit is clear.
  function automatic logic [KIND_W-1:0] mask_kind(input kind_t kind, input logic [3:0] mask);
    logic en;
    begin
      case (kind)
        KIND_DOWN:   en = mask[0];
        KIND_UP:     en = mask[1];
        KIND_LONG:   en = mask[2];
        KIND_REPEAT: en = mask[3];
        default:     en = 1'b0;
      endcase
      mask_kind = en ? kind : KIND_NONE;
    end
  endfunction

  assign in_ready    = cmd_ready;
  assign cmd_valid   = in_valid;
  assign accept_tick = in_valid && cmd_ready && !in_pop;
  assign cmd.is_pop  = in_pop;
  assign cmd.kinds   = kinds;

  always_comb begin
    logic [NUM_KEYS+KEY_LINES-1:0] keys_ext;
    logic [CNT_W-1:0]  f_lo;
    logic [CNT_W-1:0]  f_hi;
    logic [CNT_W-1:0]  step_c;
    logic [HOLD_W-1:0] step_h;
    logic [HOLD_W-1:0] lpt;
    logic [HOLD_W-1:0] rint;
    logic [HOLD_W-1:0] hold_sum;
    logic [HOLD_W-1:0] rep_sum;
    logic [CNT_W-1:0]  cnt;
    kind_t             ev0;
    kind_t             ev1;
    keys_ext = {{NUM_KEYS{1'b0}}, in_keys};
    f_lo     = CNT_W'(cfg.filter_ticks);
    f_hi     = CNT_W'({cfg.filter_ticks, 1'b0});
    step_c   = CNT_W'(cfg.tick_step);
    step_h   = HOLD_W'(cfg.tick_step);
    lpt      = HOLD_W'(cfg.long_press_time);
    rint     = HOLD_W'(cfg.repeat_interval);
    for (int k = 0; k < NUM_KEYS; k++) begin
      cnt      = debounce_count[k];
      hold_sum = hold_count[k] + step_h;
      rep_sum  = rep_count[k] + step_h;
      ev0      = KIND_NONE;
      ev1      = KIND_NONE;
      debounce_count_next[k] = cnt;
      key_is_down_next[k]    = key_is_down[k];
      hold_count_next[k]     = hold_count[k];
      rep_count_next[k]      = rep_count[k];
      if (keys_ext[k]) begin
        if (cnt < f_lo) begin
          debounce_count_next[k] = f_lo;
        end else if (cnt < f_hi) begin
          debounce_count_next[k] = cnt + step_c;
        end else begin
          if (!key_is_down[k]) begin
            key_is_down_next[k] = 1'b1;
            ev0 = KIND_DOWN;
          end
          if (lpt != '0) begin
            if (hold_count[k] < lpt) begin
              hold_count_next[k] = hold_sum;
              if (hold_sum >= lpt) begin
                ev1 = KIND_LONG;
              end
            end else if (rint != '0) begin
              if (rep_sum >= rint) begin
                rep_count_next[k] = '0;
                ev1 = KIND_REPEAT;
              end else begin
                rep_count_next[k] = rep_sum;
              end
            end
          end
        end
      end else begin
        if (cnt > f_lo) begin
          debounce_count_next[k] = f_lo;
        end else if (cnt != '0) begin
          debounce_count_next[k] = (cnt > step_c) ? cnt - step_c : '0;
        end else if (key_is_down[k]) begin
          key_is_down_next[k] = 1'b0;
          ev0 = KIND_UP;
        end
        hold_count_next[k] = '0;
        rep_count_next[k]  = '0;
      end
      kinds[2*k]   = mask_kind(ev0, cfg.report_mask);
      kinds[2*k+1] = mask_kind(ev1, cfg.report_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        debounce_count[k] <= CNT_W'(FILTER_RST);
        key_is_down[k]    <= 1'b0;
        hold_count[k]     <= '0;
        rep_count[k]      <= '0;
      end
    end else if (accept_tick) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        debounce_count[k] <= debounce_count_next[k];
        key_is_down[k]    <= key_is_down_next[k];
        hold_count[k]     <= hold_count_next[k];
        rep_count[k]      <= rep_count_next[k];
      end
    end
  end

endmodule

>>> hw/rtl/kdlr_fifo.sv
// Short request queue between the classifying front end and the event queue.
// Depends on kdlr_pkg.
module kdlr_fifo import kdlr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t                 slots [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != CMD_CNT_W'(CMD_FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [CMD_PTR_W-1:0] wrap_inc(input logic [CMD_PTR_W-1:0] p);
    wrap_inc = (p == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/kdlr_back.sv
// Back end: event queue with drop-on-full, pop handling and the result register.
// Depends on kdlr_pkg.
module kdlr_back import kdlr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [KEY_W-1:0]  out_key
);

  qentry_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head;
  logic [QPTR_W-1:0]   tail;
  logic [QFILL_W-1:0]  fill;

  logic [QPTR_W-1:0]   tail_next;
  logic [QFILL_W-1:0]  fill_next;
  logic [NUM_SLOTS-1:0] wr_en;
  logic [QPTR_W-1:0]   wr_idx [NUM_SLOTS];
  logic                take;
  logic                out_free;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = !cmd.is_pop || out_free;
  assign take      = cmd_valid && cmd_ready;

  // Place the tick's events in order behind the tail; drop those past capacity.
  always_comb begin
    logic [SLOT_W-1:0] seq;
    logic [QSUM_W-1:0] pos;
    logic [QSUM_W-1:0] tsum;
    seq = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pos       = QSUM_W'(tail) + QSUM_W'(seq);
      wr_idx[i] = (pos >= QSUM_W'(QUEUE_DEPTH)) ? QPTR_W'(pos - QSUM_W'(QUEUE_DEPTH))
                                                : QPTR_W'(pos);
      wr_en[i]  = (cmd.kinds[i] != KIND_NONE)
                  && (QSUM_W'(fill) + QSUM_W'(seq) < QSUM_W'(QUEUE_DEPTH));
      if (wr_en[i]) begin
        seq = seq + 1'b1;
      end
    end
    tsum      = QSUM_W'(tail) + QSUM_W'(seq);
    tail_next = (tsum >= QSUM_W'(QUEUE_DEPTH)) ? QPTR_W'(tsum - QSUM_W'(QUEUE_DEPTH))
                                               : QPTR_W'(tsum);
    fill_next = fill + QFILL_W'(seq);
  end

  always_ff @(posedge clk) begin
    if (take && !cmd.is_pop) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (wr_en[i]) begin
          entries[wr_idx[i]] <= '{kind: cmd.kinds[i], key: KEY_W'(i / 2)};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.is_pop) begin
      if (fill != '0) begin
        out_kind <= entries[head].kind;
        out_key  <= entries[head].key;
      end else begin
        out_kind <= KIND_NONE;
        out_key  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take && cmd.is_pop) begin
        out_valid <= 1'b1;
        if (fill != '0) begin
          head <= (head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
          fill <= fill - 1'b1;
        end
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (take) begin
          tail <= tail_next;
          fill <= fill_next;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QFILL_W'(QUEUE_DEPTH))
    else $error("event queue fill above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (head == tail))
    else $error("empty event queue with head and tail apart");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (take && cmd.is_pop && fill != '0) |=> (fill == $past(fill) - 1'b1))
    else $error("pop of a held event did not lower the fill");

  a_tick_keeps_head: assert property (@(posedge clk) disable iff (rst)
    (take && !cmd.is_pop) |=> (head == $past(head)))
    else $error("scan tick moved the read pointer");

endmodule

>>> hw/rtl/keypad_debounce_long_repeat_core.sv
// A pop is first written into the request queue; the back end takes it once its result
// register is free, loads the result register and raises m_tvalid.
// Throughput: one request (scan tick or pop) per cycle; a tick writes up to six events
// into the event queue at once. A stalled result port holds a pop in the back end, and
// once the two-entry request queue fills, s_tready drops until the result is taken.
// Reset (rst, synchronous): registers to defaults, debounce counts to 5, queue empty;
// queue entries are not cleared, no entry is read before it is written.
module keypad_debounce_long_repeat_core import kdlr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [2:0] key_pressed, [7:3] zero
  input  logic [0:0]            s_tuser,   // [0] func: 0 scan tick, 1 pop
  // event stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [1:0] event_key, [7:2] zero
  output logic [2:0]            m_tuser,   // [2:0] event_kind
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic              fr_valid;
  logic              fr_ready;
  cmd_t              fr_cmd;
  logic              bk_valid;
  logic              bk_ready;
  cmd_t              bk_cmd;
  logic [KIND_W-1:0] ev_kind;
  logic [KEY_W-1:0]  ev_key;

  // Registers always take a write; only the low bits of the data are kept.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_ticks    <= FILTER_RST;
      cfg.tick_step       <= STEP_RST;
      cfg.long_press_time <= LONG_RST;
      cfg.repeat_interval <= REPEAT_RST;
      cfg.report_mask     <= MASK_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_addr))
        REG_FILTER: cfg.filter_ticks    <= cfg_data[7:0];
        REG_STEP:   cfg.tick_step       <= cfg_data[7:0];
        REG_LONG:   cfg.long_press_time <= cfg_data[15:0];
        REG_REPEAT: cfg.repeat_interval <= cfg_data[15:0];
        REG_MASK:   cfg.report_mask     <= cfg_data[3:0];
        default:    cfg <= cfg;   // drop writes past the last register
      endcase
    end
  end

  // Front end: advance each key's debounce state on a tick and classify its events.
  kdlr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pop    (s_tuser[0]),
    .in_keys   (s_tdata[KEY_LINES-1:0]),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  // Hold classified requests so the front keeps taking input while results stall.
  kdlr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_cmd    (bk_cmd)
  );

  // Back end: queue events in order, answer pops from the oldest entry.
  kdlr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (ev_kind),
    .out_key   (ev_key)
  );

  assign m_tuser = ev_kind;
  assign m_tdata = {{(8 - KEY_W){1'b0}}, ev_key};

endmodule
